>>> rtl/exner_bed_update_sweep_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef EXNER_BED_UPDATE_SWEEP_UNIT_DEFINES_SVH
`define EXNER_BED_UPDATE_SWEEP_UNIT_DEFINES_SVH

// Implication checked every cycle outside reset.
`define EBU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: label failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define EBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

>>> rtl/ebu_pkg.sv
package ebu_pkg;

  localparam int unsigned ELEV_WIDTH_DEF = 32;
  localparam int unsigned FLUX_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned WEIGHT_W       = 17;
  localparam int unsigned GAIN_W         = 32;
  localparam int unsigned FRAC_W         = 32;
  localparam int unsigned MASS_W         = 64;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_FEED_FLUX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPWIND_WEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BED_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_GAIN    = 3'd4;

  // Operand mux selects for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SEL_NONE,
    MUL_SEL_LO,
    MUL_SEL_HI
  } mul_sel_e;

  typedef struct packed {
    logic        start;
    logic        busy;
    logic        done;
  } div_ctl_t;

  function automatic logic signed [MASS_W-1:0] sat_add64(
    input logic signed [MASS_W-1:0] a,
    input logic signed [MASS_W-1:0] b
  );
    logic signed [MASS_W:0] s;
    s = {a[MASS_W-1], a} + {b[MASS_W-1], b};
    if (s[MASS_W] != s[MASS_W-1]) begin
      sat_add64 = s[MASS_W] ? {1'b1, {(MASS_W-1){1'b0}}} : {1'b0, {(MASS_W-1){1'b1}}};
    end else begin
      sat_add64 = s[MASS_W-1:0];
    end
  endfunction

  function automatic logic signed [MASS_W-1:0] sat_sub64(
    input logic signed [MASS_W-1:0] a,
    input logic signed [MASS_W-1:0] b
  );
    logic signed [MASS_W:0] s;
    s = {a[MASS_W-1], a} - {b[MASS_W-1], b};
    if (s[MASS_W] != s[MASS_W-1]) begin
      sat_sub64 = s[MASS_W] ? {1'b1, {(MASS_W-1){1'b0}}} : {1'b0, {(MASS_W-1){1'b1}}};
    end else begin
      sat_sub64 = s[MASS_W-1:0];
    end
  endfunction

endpackage

>>> rtl/ebu_mul.sv
// Shared multiplier: 64-bit magnitude times 32-bit gain in two 32x32 passes,
// accumulated into a 96-bit product. One pass per cycle, product registered.
module ebu_mul import ebu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clr_i,
  input  mul_sel_e    sel_i,
  input  logic [63:0] a_i,
  input  logic [31:0] b_i,
  output logic [95:0] prod_o
);
  logic [95:0] prod_q, prod_d;
  logic [31:0] a_part;
  logic [63:0] pp;

  always_comb begin
    a_part = (sel_i == MUL_SEL_HI) ? a_i[63:32] : a_i[31:0];
    pp     = {32'd0, a_part} * {32'd0, b_i};
    prod_d = clr_i ? '0 : prod_q;
    case (sel_i)
      MUL_SEL_LO: prod_d = (clr_i ? 96'd0 : prod_q) + {32'd0, pp};
      MUL_SEL_HI: prod_d = (clr_i ? 96'd0 : prod_q) + {pp, 32'd0};
      default:    prod_d = clr_i ? 96'd0 : prod_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
endmodule

>>> rtl/ebu_div.sv
// Restoring divider for the discrepancy fraction: integer quotient check then
// 31 fraction bits, one bit per cycle.
module ebu_div import ebu_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [MASS_W-1:0]          num_i,
  input  logic [MASS_W-1:0]          den_i,
  input  logic                       neg_i,
  output div_ctl_t                   ctl_o,
  output logic signed [FRAC_W-1:0]   frac_o
);
  logic [MASS_W:0]   rem_q, rem_d;
  logic [MASS_W-1:0] den_q;
  logic [31:0]       f_q, f_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d, neg_q, sat_q, sat_d, qi_q, qi_d;
  logic [MASS_W:0]   sh;
  logic [MASS_W:0]   twice;
  logic [32:0]       val;
  logic [31:0]       mag;

  always_comb begin
    rem_d  = rem_q;
    f_d    = f_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    qi_d   = qi_q;
    sh     = {rem_q[MASS_W-1:0], 1'b0};
    twice  = {den_q, 1'b0};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      f_d    = '0;
      rem_d  = {1'b0, num_i};
      sat_d  = 1'b0;
      qi_d   = 1'b0;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        // integer part: 0, 1, or saturate
        if (rem_q >= twice) begin
          sat_d  = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else if (rem_q >= {1'b0, den_q}) begin
          qi_d  = 1'b1;
          rem_d = rem_q - {1'b0, den_q};
        end
        cnt_d = 6'd1;
      end else begin
        if (sh >= {1'b0, den_q}) begin
          rem_d = sh - {1'b0, den_q};
          f_d   = {f_q[30:0], 1'b1};
        end else begin
          rem_d = sh;
          f_d   = {f_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    f_q   <= f_d;
    sat_q <= sat_d;
    qi_q  <= qi_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= neg_i;
    end
  end

  always_comb begin
    val = sat_q ? 33'h100000000 : ({1'b0, qi_q, f_q[30:0]} + 33'd1) >> 1;
    if (!neg_q) begin
      mag    = (val > 33'h07FFFFFFF) ? 32'h7FFFFFFF : val[31:0];
      frac_o = mag;
    end else begin
      mag    = (val > 33'h080000000) ? 32'h80000000 : val[31:0];
      frac_o = 32'd0 - mag;
    end
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
endmodule

>>> rtl/exner_bed_update_sweep_unit.sv
// A node's result is made once the next node is taken and is loaded at its emit step; on
// the last node the pair result comes first, then the last node's update, the mass
// multiply and, for positive inflow mass, the divider give the end-of-sweep result.
// Nodes are taken only in idle; the 32x32 multiplier (two passes per product) and the
// one-bit-per-cycle divider set the pace. A held result stalls the output steps. Reset:
// asynchronous active low; registers reset, totals zero, next node starts a sweep.
module exner_bed_update_sweep_unit import ebu_pkg::*; #(
  parameter int unsigned ELEV_WIDTH = ELEV_WIDTH_DEF,
  parameter int unsigned FLUX_WIDTH = FLUX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [ELEV_WIDTH-1:0] bed_elevation_i,
  input  logic [FLUX_WIDTH-1:0]        bedload_flux_i,
  input  logic [FLUX_WIDTH-1:0]        suspended_flux_i,
  input  logic                         last_node_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [ELEV_WIDTH-1:0] updated_elevation_o,
  output logic                         end_of_sweep_o,
  output logic signed [FRAC_W-1:0]     discrepancy_fraction_o,
  output logic                         discrepancy_valid_o
);
  // flux totals must also hold the 32-bit feed flux
  localparam int unsigned QW = (FLUX_WIDTH >= 32) ? FLUX_WIDTH + 1 : 33;
  localparam logic signed [63:0] EMAX = 64'sd1 <<< (ELEV_WIDTH - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_FIRST_M0, S_FIRST_M1, S_FIRST_ACC,
    S_UPD_SETUP, S_UPD_B0, S_UPD_B1, S_UPD_RND,
    S_UPD_S0, S_UPD_S1, S_UPD_SACC, S_EMIT, S_WAIT_OUT,
    S_OUT_M0, S_OUT_M1, S_OUT_ACC, S_DIV_START, S_DIV_WAIT, S_FINAL
  } state_e;

  state_e state_q;

  logic [31:0]         feed_q, bed_gain_q, mass_gain_q, store_gain_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [QW-1:0]       f2_q, f1_q, qin_q;
  logic signed [ELEV_WIDTH-1:0] held_q, eta_q;
  logic                first_q, last_q, second_q;
  logic signed [63:0]  min_q, mout_q, mst_q;
  logic signed [63:0]  diff_q;
  logic signed [63:0]  old_q, new_q;
  logic [63:0]         a_q;
  logic [31:0]         b_q;
  logic                neg_q;
  mul_sel_e            sel_q;
  logic                clr_q;
  logic [95:0]         prod;

  logic                ov_q, eos_q, dv_q;
  logic signed [ELEV_WIDTH-1:0] oe_q;
  logic signed [FRAC_W-1:0]     of_q;
  logic                out_free, ov_load;

  div_ctl_t            dctl;
  logic                dstart;
  logic signed [FRAC_W-1:0] dfrac;
  logic signed [63:0]  num_s;
  logic [63:0]         num_mag;

  logic [WEIGHT_W-1:0] w;
  logic signed [63:0]  wt, wc;
  logic [QW-1:0]       qsum;

  assign w    = (weight_q > ONE_Q16) ? ONE_Q16 : weight_q;
  assign wt   = {{(64-WEIGHT_W){1'b0}}, w};
  assign wc   = {{(64-WEIGHT_W){1'b0}}, ONE_Q16 - w};
  assign qsum = QW'(bedload_flux_i) + QW'(suspended_flux_i);

  ebu_mul u_mul (
    .clk_i (clk_i), .rst_ni(rst_ni), .clr_i(clr_q), .sel_i(sel_q),
    .a_i   (a_q), .b_i(b_q), .prod_o(prod)
  );

  assign num_s   = sat_sub64(sat_sub64(min_q, mst_q), mout_q);
  assign num_mag = num_s[63] ? 64'd0 - num_s : num_s;
  assign dstart  = (state_q == S_DIV_START);

  ebu_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dstart), .num_i(num_mag),
    .den_i(min_q), .neg_i(num_s[63]), .ctl_o(dctl), .frac_o(dfrac)
  );

  assign in_stall_o = (state_q != S_IDLE);

  // output register is free when empty or its result transfers this cycle
  assign out_free = !ov_q || !out_stall_i;
  assign ov_load  = out_free &&
                    (((state_q == S_EMIT) && !(last_q && second_q)) ||
                     ((state_q == S_DIV_START) && (min_q <= 64'sd0)) ||
                     (state_q == S_FINAL));

  // rounding helpers on the 96-bit product
  logic [95:0] r44, r28, r12;
  logic [63:0] m44, m28, m12;
  assign r44 = (prod >> 44) + {95'd0, prod[43]};
  assign r28 = (prod >> 28) + {95'd0, prod[27]};
  assign r12 = (prod >> 12) + {95'd0, prod[11]};
  assign m44 = (r44[95:63] != 0) ? 64'h7FFFFFFFFFFFFFFF : r44[63:0];
  assign m28 = (r28[95:63] != 0) ? 64'h7FFFFFFFFFFFFFFF : r28[63:0];
  assign m12 = (r12[95:63] != 0) ? 64'h7FFFFFFFFFFFFFFF : r12[63:0];

  logic signed [63:0] dchg, esum, esat, sinc, ediff;
  logic [63:0] pmag0;
  assign pmag0 = (prod[95:63] != 0) ? 64'h7FFFFFFFFFFFFFFF : prod[63:0];
  assign dchg  = neg_q ? -$signed(m44) : $signed(m44);
  assign esum  = sat_add64(old_q, dchg);
  assign esat  = (esum > EMAX - 64'sd1) ? EMAX - 64'sd1 : ((esum < -EMAX) ? -EMAX : esum);
  assign sinc  = neg_q ? -$signed(pmag0) : $signed(pmag0);
  assign ediff = new_q - old_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      feed_q <= '0; weight_q <= ONE_Q16; bed_gain_q <= '0;
      mass_gain_q <= '0; store_gain_q <= '0;
      f2_q <= '0; f1_q <= '0; held_q <= '0; first_q <= 1'b1;
      min_q <= '0; mout_q <= '0; mst_q <= '0;
      ov_q <= 1'b0; sel_q <= MUL_SEL_NONE; clr_q <= 1'b0;
      eos_q <= 1'b0; dv_q <= 1'b0; of_q <= '0; oe_q <= '0;
      last_q <= 1'b0; second_q <= 1'b0;
      qin_q <= '0; eta_q <= '0; diff_q <= '0; old_q <= '0; new_q <= '0;
      a_q <= '0; b_q <= '0; neg_q <= 1'b0;
    end else begin
      sel_q <= MUL_SEL_NONE;
      clr_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FEED_FLUX:     feed_q       <= cfg_data_i;
          REG_UPWIND_WEIGHT: weight_q     <= cfg_data_i[WEIGHT_W-1:0];
          REG_BED_GAIN:      bed_gain_q   <= cfg_data_i;
          REG_MASS_GAIN:     mass_gain_q  <= cfg_data_i;
          REG_STORE_GAIN:    store_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ov_load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            qin_q  <= qsum;
            eta_q  <= bed_elevation_i;
            last_q <= last_node_i;
            if (first_q) begin
              // inflow blend, fits 49 bits
              a_q   <= wt * {{(64-QW){1'b0}}, QW'(feed_q)} +
                       wc * {{(64-QW){1'b0}}, qsum};
              b_q   <= mass_gain_q;
              clr_q <= 1'b1;
              sel_q <= MUL_SEL_LO;
              state_q <= S_FIRST_M0;
            end else begin
              diff_q <= wt * ($signed({{(64-QW){1'b0}}, f2_q}) -
                              $signed({{(64-QW){1'b0}}, f1_q})) +
                        wc * ($signed({{(64-QW){1'b0}}, f1_q}) -
                              $signed({{(64-QW){1'b0}}, qsum}));
              old_q    <= 64'(held_q);
              second_q <= 1'b0;
              state_q  <= S_UPD_SETUP;
            end
          end
        end
        S_FIRST_M0: begin
          sel_q <= MUL_SEL_HI;
          state_q <= S_FIRST_M1;
        end
        S_FIRST_M1: state_q <= S_FIRST_ACC;
        S_FIRST_ACC: begin
          min_q   <= sat_add64(min_q, $signed(m28));
          f2_q    <= QW'(feed_q);
          f1_q    <= qin_q;
          held_q  <= eta_q;
          first_q <= 1'b0;
          if (last_q) begin
            diff_q   <= ($signed({{(64-QW){1'b0}}, QW'(feed_q)}) -
                         $signed({{(64-QW){1'b0}}, qin_q})) <<< 16;
            old_q    <= 64'(eta_q);
            second_q <= 1'b1;
            state_q  <= S_UPD_SETUP;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_UPD_SETUP: begin
          neg_q <= diff_q[63];
          a_q   <= diff_q[63] ? 64'd0 - diff_q : diff_q;
          b_q   <= bed_gain_q;
          clr_q <= 1'b1;
          sel_q <= MUL_SEL_LO;
          state_q <= S_UPD_B0;
        end
        S_UPD_B0: begin
          sel_q <= MUL_SEL_HI;
          state_q <= S_UPD_B1;
        end
        S_UPD_B1: state_q <= S_UPD_RND;
        S_UPD_RND: begin
          new_q <= esat;
          state_q <= S_UPD_S0;
        end
        S_UPD_S0: begin
          neg_q <= ediff[63];
          a_q   <= ediff[63] ? 64'd0 - ediff : ediff;
          b_q   <= store_gain_q;
          clr_q <= 1'b1;
          sel_q <= MUL_SEL_LO;
          state_q <= S_UPD_S1;
        end
        S_UPD_S1: begin
          sel_q <= MUL_SEL_HI;
          state_q <= S_UPD_SACC;
        end
        S_UPD_SACC: state_q <= S_EMIT;
        S_EMIT: begin
          // waits here while an earlier result still sits in the output register
          if (out_free) begin
            mst_q <= sat_add64(mst_q, sinc);
            if (second_q || !last_q) begin
              if (!last_q) begin
                f2_q   <= f1_q;
                f1_q   <= qin_q;
                held_q <= eta_q;
              end
              oe_q <= new_q[ELEV_WIDTH-1:0];
            end else begin
              oe_q <= new_q[ELEV_WIDTH-1:0];
            end
            if (!last_q) begin
              eos_q <= 1'b0; of_q <= '0; dv_q <= 1'b0;
              state_q <= S_IDLE;
            end else if (!second_q) begin
              // interior result of the last pair, then the last node itself
              eos_q <= 1'b0; of_q <= '0; dv_q <= 1'b0;
              diff_q   <= ($signed({{(64-QW){1'b0}}, f1_q}) -
                           $signed({{(64-QW){1'b0}}, qin_q})) <<< 16;
              old_q    <= 64'(eta_q);
              second_q <= 1'b1;
              state_q  <= S_WAIT_OUT;
            end else begin
              a_q   <= {{(64-QW){1'b0}}, qin_q};
              b_q   <= mass_gain_q;
              clr_q <= 1'b1;
              sel_q <= MUL_SEL_LO;
              state_q <= S_OUT_M0;
            end
          end
        end
        S_WAIT_OUT: begin
          if (out_free) state_q <= S_UPD_SETUP;
        end
        S_OUT_M0: begin
          sel_q <= MUL_SEL_HI;
          state_q <= S_OUT_M1;
        end
        S_OUT_M1: state_q <= S_OUT_ACC;
        S_OUT_ACC: begin
          mout_q <= sat_add64(mout_q, $signed(m12));
          state_q <= S_DIV_START;
        end
        S_DIV_START: begin
          if (min_q <= 64'sd0) begin
            if (out_free) begin
              eos_q <= 1'b1; of_q <= '0; dv_q <= 1'b0;
              first_q <= 1'b1;
              state_q <= S_IDLE;
            end
          end else begin
            state_q <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (dctl.done) state_q <= S_FINAL;
        end
        S_FINAL: begin
          if (out_free) begin
            eos_q <= 1'b1; of_q <= dfrac; dv_q <= 1'b1;
            first_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o            = ov_q;
  assign updated_elevation_o    = oe_q;
  assign end_of_sweep_o         = eos_q;
  assign discrepancy_fraction_o = of_q;
  assign discrepancy_valid_o    = dv_q;
endmodule

>>> rtl/ebu_checker.sv
module ebu_checker import ebu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        end_of_sweep_o,
  input logic        discrepancy_valid_o,
  input logic [31:0] discrepancy_fraction_o
);
`include "exner_bed_update_sweep_unit_defines.svh"

  `EBU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `EBU_ASSERT_IMP(a_dv_eos, clk_i, rst_ni, out_valid_o && discrepancy_valid_o, end_of_sweep_o)
  `EBU_ASSERT_IMP(a_frac_zero, clk_i, rst_ni, out_valid_o && !end_of_sweep_o, discrepancy_fraction_o == 32'd0)
  `EBU_ASSERT_IMP(a_busy_after_in, clk_i, rst_ni, $past(rst_ni && in_valid_i && !in_stall_o), in_stall_o)
endmodule

bind exner_bed_update_sweep_unit ebu_checker u_ebu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .end_of_sweep_o(end_of_sweep_o),
  .discrepancy_valid_o(discrepancy_valid_o), .discrepancy_fraction_o(discrepancy_fraction_o)
);
